/* src/afs_pkg.sv */
// Package for the animation frame stepper: register map, reset values,
// configuration struct and sequencer states. No dependencies.
package afs_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int FRAMES_W    = 16;
    localparam int PERIOD_W    = 32;
    localparam int SPEED_W     = 16;
    localparam int DT_W        = 32;
    localparam int PASSES_W    = 16;
    localparam int SPEED_FRAC  = 8;
    localparam int PROD_W      = SPEED_W + DT_W;
    localparam int SCALED_W    = PROD_W - SPEED_FRAC;
    localparam int OUT_FRAME_W = 16;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FRAME_W - 3;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_SPEED   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_FORWARD = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT   = CFG_IDX_W'(4);

    localparam logic [FRAMES_W-1:0] RST_TOTAL_FRAMES = FRAMES_W'(1);
    localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD = PERIOD_W'(2185);
    localparam logic [SPEED_W-1:0]  RST_PLAY_SPEED   = SPEED_W'(256);
    localparam logic                RST_PLAY_FORWARD = 1'b1;
    localparam logic [PASSES_W-1:0] RST_LOOP_COUNT   = PASSES_W'(0);

    // settings as the datapath sees them; zero frame counts and periods act as one
    typedef struct packed {
        logic [FRAMES_W-1:0] frames_eff;
        logic [PERIOD_W-1:0] period_eff;
        logic [SPEED_W-1:0]  speed;
        logic                forward;
        logic [PASSES_W-1:0] loop_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DIV1,
        ST_ADV,
        ST_DIV2,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

/* src/afs_cfg.sv */
// Configuration register file for the animation frame stepper.
// Depends on afs_pkg.
module afs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [afs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0] cfg_data,
    output afs_pkg::cfg_t                  cfg
);
    import afs_pkg::*;

    logic [FRAMES_W-1:0] total_frames_reg;
    logic [PERIOD_W-1:0] frame_period_reg;
    logic [SPEED_W-1:0]  play_speed_reg;
    logic                play_forward_reg;
    logic [PASSES_W-1:0] loop_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg <= RST_TOTAL_FRAMES;
            frame_period_reg <= RST_FRAME_PERIOD;
            play_speed_reg   <= RST_PLAY_SPEED;
            play_forward_reg <= RST_PLAY_FORWARD;
            loop_count_reg   <= RST_LOOP_COUNT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TOTAL_FRAMES: total_frames_reg <= cfg_data[FRAMES_W-1:0];
                REG_FRAME_PERIOD: frame_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_PLAY_SPEED:   play_speed_reg   <= cfg_data[SPEED_W-1:0];
                REG_PLAY_FORWARD: play_forward_reg <= cfg_data[0];
                REG_LOOP_COUNT:   loop_count_reg   <= cfg_data[PASSES_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.frames_eff = (total_frames_reg == '0) ? FRAMES_W'(1) : total_frames_reg;
        cfg.period_eff = (frame_period_reg == '0) ? PERIOD_W'(1) : frame_period_reg;
        cfg.speed      = play_speed_reg;
        cfg.forward    = play_forward_reg;
        cfg.loop_count = loop_count_reg;
    end

endmodule

/* src/afs_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing; quotient and remainder hold until the next start.
module afs_div #(
    parameter int DW = 32,
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [VW:0]   shifted;
    logic [VW:0]   trial;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
            // remainder stays below the divisor, so a fitting trial fits VW bits
            quo_next  = {quo_reg[DW-2:0], ~trial[VW]};
            rem_next  = trial[VW] ? shifted[VW-1:0] : trial[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* src/animation_frame_stepper.sv */
// Sprite animation frame timer. Restart requests (tuser 1) and ticks while stopped go
// straight to the result state; a tick that stays inside the current frame passes the
// multiply and compare states first. A tick that steps frames runs one division of the
// spent time by the frame period on the shared divider; wrapping across the sequence end
// adds a second division by the frame count. The divisions and a stalled output
// (m_tready low) set the rate; s_tready is low while an item is at work.
// Depends on afs_pkg, afs_cfg and afs_div.
module animation_frame_stepper #(
    parameter int FRAME_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [afs_pkg::DT_W-1:0]        s_tdata,    // delta_time
    input  logic                            s_tuser,    // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame[15:0], frame_changed, end_reached, is_playing, zero pad
    output logic [afs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import afs_pkg::*;

    localparam int NW = ((TIME_BITS > FRAME_BITS) ? TIME_BITS : FRAME_BITS) + 1;

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [FRAME_BITS-1:0]  cur_frame_reg, cur_frame_next;
    logic [TIME_BITS-1:0]   rem_time_reg, rem_time_next;
    logic [PASSES_W-1:0]    passes_reg, passes_next;
    logic                   running_reg, running_next;
    logic [FRAME_BITS-1:0]  before_reg, before_next;
    logic                   ended_reg, ended_next;
    logic [DT_W-1:0]        dt_reg, dt_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [NW-1:0]          d_reg, d_next;
    logic [TIME_BITS:0]     n_reg, n_next;
    logic [PERIOD_W-1:0]    m_reg, m_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                   div_start;
    logic [TIME_BITS-1:0]   div_dividend;
    logic [PERIOD_W-1:0]    div_divisor;
    logic                   div_done;
    logic [TIME_BITS-1:0]   div_quo;
    logic [PERIOD_W-1:0]    div_rem;

    logic                   in_accept;
    logic                   out_free;
    logic [SCALED_W-1:0]    scaled_full;
    logic                   scaled_sat;
    logic [TIME_BITS-1:0]   scaled;
    logic [TIME_BITS:0]     rem_minus_a;
    logic [TIME_BITS-1:0]   a_minus_rem;
    logic                   short_tick;
    logic [NW:0]            n_minus_d;
    logic                   n_lt_d;
    logic                   hold_at_end;
    logic                   fin_stop;
    logic [TIME_BITS-1:0]   rem_from_m;
    logic [FRAME_BITS-1:0]  start_frame;
    logic [FRAME_BITS-1:0]  last_frame;
    logic [FRAME_BITS-1:0]  wrap_frame;
    logic [FRAMES_W-1:0]    lo;

    afs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afs_div #(
        .DW (TIME_BITS),
        .VW (PERIOD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // scaled time, saturated to TIME_BITS
    assign scaled_full = prod_reg[PROD_W-1:SPEED_FRAC];
    assign scaled_sat  = ((scaled_full >> TIME_BITS) != '0);
    assign scaled      = scaled_sat ? '1 : TIME_BITS'(scaled_full);
    assign rem_minus_a = {1'b0, rem_time_reg} - {1'b0, scaled};
    assign a_minus_rem = scaled - rem_time_reg;
    assign short_tick  = !rem_minus_a[TIME_BITS] && (rem_minus_a != '0);

    assign n_minus_d   = {1'b0, NW'(n_reg)} - {1'b0, d_reg};
    assign n_lt_d      = n_minus_d[NW];
    assign hold_at_end = (passes_reg == PASSES_W'(1));

    assign fin_stop    = (div_quo != '0) && (passes_reg != '0)
                         && (div_quo >= TIME_BITS'(passes_reg));
    assign rem_from_m  = TIME_BITS'(cfg.period_eff - m_reg);
    assign lo          = div_rem[FRAMES_W-1:0];

    assign start_frame = cfg.forward ? '0 : FRAME_BITS'(cfg.frames_eff - FRAMES_W'(1));
    assign last_frame  = cfg.forward ? FRAME_BITS'(cfg.frames_eff - FRAMES_W'(1)) : '0;
    assign wrap_frame  = cfg.forward ? FRAME_BITS'(lo)
                                     : FRAME_BITS'(cfg.frames_eff - FRAMES_W'(1) - lo);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_tuser || !running_reg) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_CMP;
            ST_CMP:  state_next = short_tick ? ST_DONE : ST_DIV1;
            ST_DIV1: state_next = div_done ? ST_ADV : ST_DIV1;
            ST_ADV:  state_next = (n_lt_d || hold_at_end) ? ST_DONE : ST_DIV2;
            ST_DIV2: state_next = div_done ? ST_FIN : ST_DIV2;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        cur_frame_next = cur_frame_reg;
        rem_time_next  = rem_time_reg;
        passes_next    = passes_reg;
        running_next   = running_reg;
        before_next    = before_reg;
        ended_next     = ended_reg;
        dt_next        = dt_reg;
        prod_next      = prod_reg;
        d_next         = d_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    dt_next     = s_tdata;
                    before_next = cur_frame_reg;
                    ended_next  = 1'b0;
                    if (s_tuser)
                    begin
                        cur_frame_next = start_frame;
                        rem_time_next  = TIME_BITS'(cfg.period_eff);
                        passes_next    = cfg.loop_count;
                        running_next   = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = PROD_W'(cfg.speed) * PROD_W'(dt_reg);
                // steps to the end of the sequence from here
                if (cfg.forward)
                begin
                    d_next = (NW'(cur_frame_reg) >= NW'(cfg.frames_eff))
                             ? NW'(1) : NW'(cfg.frames_eff) - NW'(cur_frame_reg);
                end
                else
                begin
                    d_next = NW'(cur_frame_reg) + NW'(1);
                end
            end
            ST_CMP:
            begin
                if (short_tick)
                begin
                    rem_time_next = rem_minus_a[TIME_BITS-1:0];
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = a_minus_rem;
                    div_divisor  = cfg.period_eff;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    n_next = {1'b0, div_quo} + (TIME_BITS+1)'(1);
                    m_next = div_rem;
                end
            end
            ST_ADV:
            begin
                if (n_lt_d)
                begin
                    cur_frame_next = cfg.forward
                                     ? FRAME_BITS'(NW'(cur_frame_reg) + NW'(n_reg))
                                     : FRAME_BITS'(NW'(cur_frame_reg) - NW'(n_reg));
                    rem_time_next  = rem_from_m;
                end
                else
                begin
                    ended_next = 1'b1;
                    if (hold_at_end)
                    begin
                        passes_next    = '0;
                        running_next   = 1'b0;
                        cur_frame_next = last_frame;
                        rem_time_next  = '0;
                    end
                    else
                    begin
                        if (passes_reg != '0)
                        begin
                            passes_next = passes_reg - PASSES_W'(1);
                        end
                        // whole passes and offset into the last one
                        div_start    = 1'b1;
                        div_dividend = TIME_BITS'(n_minus_d);
                        div_divisor  = PERIOD_W'(cfg.frames_eff);
                    end
                end
            end
            ST_DIV2: ;
            ST_FIN:
            begin
                if (fin_stop)
                begin
                    passes_next    = '0;
                    running_next   = 1'b0;
                    cur_frame_next = last_frame;
                    rem_time_next  = '0;
                end
                else
                begin
                    if ((div_quo != '0) && (passes_reg != '0))
                    begin
                        passes_next = passes_reg - PASSES_W'(div_quo);
                    end
                    cur_frame_next = wrap_frame;
                    rem_time_next  = rem_from_m;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, running_reg, ended_reg,
                                      (cur_frame_reg != before_reg),
                                      OUT_FRAME_W'(cur_frame_reg)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_frame_reg <= '0;
            rem_time_reg  <= '0;
            passes_reg    <= '0;
            running_reg   <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_frame_reg <= cur_frame_next;
            rem_time_reg  <= rem_time_next;
            passes_reg    <= passes_next;
            running_reg   <= running_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        before_reg   <= before_next;
        dt_reg       <= dt_next;
        prod_reg     <= prod_next;
        d_reg        <= d_next;
        n_reg        <= n_next;
        m_reg        <= m_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider finished outside a division wait");

    a_stopped_no_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !running_reg) |-> (rem_time_reg == '0))
        else $error("time left in frame while stopped");

    a_stop_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(running_reg) |-> ended_reg)
        else $error("playback stopped without crossing the end");
`endif

endmodule

/* test/animation_frame_stepper_tb.sv */
// Testbench for animation_frame_stepper: a directed table, then random phases under mostly
// random register settings, every result checked in order against a typed value or a frame-timer predictor.
// Depends on afs_pkg and the animation_frame_stepper RTL.
`timescale 1ns / 1ps

module animation_frame_stepper_tb;
    import afs_pkg::*;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;
    localparam int   RUN_LIMIT   = 200000;
    localparam int   HOLD_OFF    = 150;
    localparam int   FLUSH_WAIT  = 80;
    localparam int   PHASES      = 12;
    localparam int   PHASE_ITEMS = 36;

    typedef struct packed {
        logic [15:0] frame;
        logic        changed;
        logic        ended;
        logic        playing;
    } frame_report_t;

    typedef enum logic [1:0] {ROW_SET, ROW_GO, ROW_TYPED} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic [2:0]    reg_idx;
        logic          cmd;
        logic [31:0]   value;    // register value or delta time
        frame_report_t typed;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DT_W-1:0]       s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers and the playback state
    logic [15:0] cfg_frames = RST_TOTAL_FRAMES;
    logic [31:0] cfg_period = RST_FRAME_PERIOD;
    logic [15:0] cfg_speed  = RST_PLAY_SPEED;
    logic        cfg_fwd    = RST_PLAY_FORWARD;
    logic [15:0] cfg_loops  = RST_LOOP_COUNT;
    logic [15:0] pos_frame  = '0;
    logic [31:0] time_left  = '0;
    logic [15:0] passes     = '0;
    logic        playing    = 1'b0;

    frame_report_t frames_due[$];
    stim_row_t     script[$];
    int            mismatches   = 0;
    int            results_seen = 0;
    int            cycle_count  = 0;
    bit            idle_on      = 1'b1;

    animation_frame_stepper DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one pass over the sequence end; 1 means playback wraps
    function automatic bit end_wraps();
        if (passes == 16'd0)
            return 1'b1;
        if (passes == 16'd1)
        begin
            passes  = 16'd0;
            playing = 1'b0;
            return 1'b0;
        end
        passes = passes - 16'd1;
        return 1'b1;
    endfunction

    // n frame steps in closed form; returns 1 if the end was crossed
    function automatic bit step_frames(longint unsigned n);
        longint unsigned t, to_end, start_fr, end_fr, rest, laps, lo;
        t = (cfg_frames == 16'd0) ? 64'd1 : 64'(cfg_frames);
        if (cfg_fwd)
            to_end = (pos_frame >= t) ? 64'd1 : t - pos_frame;
        else
            to_end = 64'(pos_frame) + 64'd1;
        if (n < to_end)
        begin
            pos_frame = cfg_fwd ? 16'(pos_frame + n) : 16'(pos_frame - n);
            return 1'b0;
        end
        start_fr = cfg_fwd ? 64'd0 : t - 64'd1;
        end_fr   = cfg_fwd ? t - 64'd1 : 64'd0;
        if (!end_wraps())
        begin
            pos_frame = 16'(end_fr);
            return 1'b1;
        end
        rest = n - to_end;
        laps = rest / t;
        lo   = rest % t;
        if (laps > 0 && passes != 16'd0)
        begin
            if (laps >= passes)
            begin
                passes    = 16'd0;
                playing   = 1'b0;
                pos_frame = 16'(end_fr);
                return 1'b1;
            end
            passes = passes - 16'(laps);
        end
        pos_frame = cfg_fwd ? 16'(start_fr + lo) : 16'(start_fr - lo);
        return 1'b1;
    endfunction

    function automatic frame_report_t predict_frame(logic cmd, logic [31:0] dt);
        frame_report_t   rep;
        logic [15:0]     was;
        longint unsigned period, scaled, spd, dtl;
        bit              crossed;
        was     = pos_frame;
        crossed = 1'b0;
        period  = (cfg_period == 32'd0) ? 64'd1 : 64'(cfg_period);
        if (cmd == CMD_RESTART)
        begin
            pos_frame = cfg_fwd ? 16'd0 :
                        (cfg_frames == 16'd0) ? 16'd0 : cfg_frames - 16'd1;
            time_left = 32'(period);
            passes    = cfg_loops;
            playing   = 1'b1;
        end
        else if (playing)
        begin
            spd    = cfg_speed;
            dtl    = dt;
            scaled = (spd * dtl) >> 8;
            if (scaled > 64'hFFFF_FFFF)
                scaled = 64'hFFFF_FFFF;
            if (scaled < time_left)
                time_left = time_left - 32'(scaled);
            else
            begin
                scaled    = scaled - time_left;
                crossed   = step_frames(64'd1 + scaled / period);
                time_left = playing ? 32'(period - scaled % period) : 32'd0;
            end
        end
        rep.frame   = pos_frame;
        rep.changed = (pos_frame != was);
        rep.ended   = crossed;
        rep.playing = playing;
        return rep;
    endfunction

    function automatic void add_set(logic [2:0] idx, logic [31:0] val);
        stim_row_t row;
        row.kind    = ROW_SET;
        row.reg_idx = idx;
        row.cmd     = CMD_TICK;
        row.value   = val;
        row.typed   = '0;
        script.push_back(row);
    endfunction

    function automatic void add_go(logic cmd, logic [31:0] dt, bit typed, frame_report_t rep);
        stim_row_t row;
        row.kind    = typed ? ROW_TYPED : ROW_GO;
        row.reg_idx = '0;
        row.cmd     = cmd;
        row.value   = dt;
        row.typed   = rep;
        script.push_back(row);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TOTAL_FRAMES: cfg_frames = val[15:0];
            REG_FRAME_PERIOD: cfg_period = val;
            REG_PLAY_SPEED:   cfg_speed  = val[15:0];
            REG_PLAY_FORWARD: cfg_fwd    = val[0];
            REG_LOOP_COUNT:   cfg_loops  = val[15:0];
            default: ;
        endcase
    endtask

    // stop offering and let every outstanding request come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic offer_request(logic cmd, logic [31:0] dt, bit typed, frame_report_t rep);
        int            gap;
        frame_report_t want;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= dt;
        do
            @(posedge clk);
        while (!s_tready);
        want = predict_frame(cmd, dt);
        frames_due.push_back(typed ? rep : want);
    endtask

    // result side: random stalls, two long hold-offs, in-order checking
    initial
    begin
        int            stall;
        frame_report_t got;
        frame_report_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (results_seen == 40 || results_seen == 200)
                stall = HOLD_OFF;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            results_seen++;
            got = {m_tdata[15:0], m_tdata[16], m_tdata[17], m_tdata[18]};
            if (frames_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result frame=%0d chg=%b end=%b play=%b",
                         $time, got.frame, got.changed, got.ended, got.playing);
            end
            else
            begin
                want = frames_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: exp f=%0d c=%b e=%b p=%b, got f=%0d c=%b e=%b p=%b",
                             $time, want.frame, want.changed, want.ended, want.playing,
                             got.frame, got.changed, got.ended, got.playing);
                end
            end
        end
    end

    // request side
    initial
    begin
        stim_row_t       row;
        logic            cmd;
        logic [31:0]     dt;
        logic [15:0]     f_pick, s_pick, l_pick;
        logic [31:0]     p_pick;
        longint unsigned span, t_eff;

        // straight after reset: stopped, then restart with the reset settings
        add_go(CMD_TICK,    32'hFFFF_FFFF, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b0});
        add_go(CMD_RESTART, 32'hFFFF_FFFF, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b1});
        add_go(CMD_TICK,    32'd0,         1'b1, '{16'd0, 1'b0, 1'b0, 1'b1});
        // zero period acts as one
        add_set(REG_TOTAL_FRAMES, 32'd8);
        add_set(REG_FRAME_PERIOD, 32'd0);
        add_go(CMD_RESTART, 32'd0,  1'b1, '{16'd0, 1'b0, 1'b0, 1'b1});
        add_go(CMD_TICK,    32'd1,  1'b0, '0);
        add_go(CMD_TICK,    32'd20, 1'b0, '0);
        // top speed, saturated product, passes run out in one tick
        add_set(REG_TOTAL_FRAMES, 32'd5);
        add_set(REG_FRAME_PERIOD, 32'h0001_0000);
        add_set(REG_PLAY_SPEED,   32'd65535);
        add_set(REG_LOOP_COUNT,   32'd3);
        add_go(CMD_RESTART, 32'd0,         1'b0, '0);
        add_go(CMD_TICK,    32'hFFFF_FFFF, 1'b1, '{16'd4, 1'b1, 1'b1, 1'b0});
        add_go(CMD_TICK,    32'h0001_0000, 1'b1, '{16'd4, 1'b0, 1'b0, 1'b0});
        // downward at zero speed
        add_set(REG_PLAY_FORWARD, 32'd0);
        add_set(REG_PLAY_SPEED,   32'd0);
        add_set(REG_LOOP_COUNT,   32'd1);
        add_go(CMD_RESTART, 32'd7,         1'b1, '{16'd4, 1'b0, 1'b0, 1'b1});
        add_go(CMD_TICK,    32'hFFFF_FFFF, 1'b1, '{16'd4, 1'b0, 1'b0, 1'b1});
        // longest period
        add_set(REG_PLAY_SPEED,   32'd256);
        add_set(REG_FRAME_PERIOD, 32'hFFFF_FFFF);
        add_go(CMD_RESTART, 32'd0,         1'b1, '{16'd4, 1'b0, 1'b0, 1'b1});
        add_go(CMD_TICK,    32'hFFFF_FFFF, 1'b0, '0);
        add_go(CMD_TICK,    32'd1,         1'b0, '0);
        // zero frame count with the frame left beyond the end
        add_set(REG_TOTAL_FRAMES, 32'd0);
        add_set(REG_FRAME_PERIOD, 32'd1);
        add_set(REG_PLAY_FORWARD, 32'd1);
        add_set(REG_LOOP_COUNT,   32'd2);
        add_go(CMD_TICK,    32'hFFFF_FFFF, 1'b0, '0);
        add_go(CMD_RESTART, 32'd0,         1'b0, '0);
        add_go(CMD_TICK,    32'd2,         1'b0, '0);
        // largest sequence and loop count, downward
        add_set(REG_TOTAL_FRAMES, 32'd65535);
        add_set(REG_LOOP_COUNT,   32'd65535);
        add_set(REG_PLAY_FORWARD, 32'd0);
        add_go(CMD_RESTART, 32'd0,          1'b0, '0);
        add_go(CMD_TICK,    32'h0001_0000,  1'b0, '0);
        add_go(CMD_TICK,    32'h0000_FFFF,  1'b0, '0);
        // turn upward with the frame far beyond a short sequence
        add_set(REG_PLAY_FORWARD, 32'd1);
        add_set(REG_TOTAL_FRAMES, 32'd3);
        add_go(CMD_TICK,    32'd1, 1'b0, '0);
        add_go(CMD_TICK,    32'd5, 1'b0, '0);

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_SET)
            begin
                wait_drained();
                write_reg(row.reg_idx, row.value);
            end
            else
                offer_request(row.cmd, row.value, row.kind == ROW_TYPED, row.typed);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       f_pick = 16'd1;
                1:       f_pick = 16'($urandom_range(2, 12));
                2:       f_pick = 16'($urandom_range(0, 65535));
                default: f_pick = 16'd65535;
            endcase
            case ($urandom_range(0, 3))
                0:       p_pick = $urandom_range(1, 16);
                1:       p_pick = $urandom_range(1, 131072);
                2:       p_pick = $urandom;
                default: p_pick = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 3))
                0:       s_pick = 16'd256;
                1:       s_pick = 16'($urandom_range(0, 1024));
                2:       s_pick = 16'($urandom_range(0, 65535));
                default: s_pick = 16'd65535;
            endcase
            case ($urandom_range(0, 3))
                0:       l_pick = 16'd0;
                1:       l_pick = 16'($urandom_range(1, 4));
                2:       l_pick = 16'($urandom_range(0, 65535));
                default: l_pick = 16'd65535;
            endcase
            // first two phases pin the opposite corners
            if (phase == 0)
            begin
                f_pick = 16'd65535; p_pick = 32'd1; s_pick = 16'd65535; l_pick = 16'd65535;
            end
            else if (phase == 1)
            begin
                f_pick = 16'd1; p_pick = 32'hFFFF_FFFF; s_pick = 16'd65535; l_pick = 16'd1;
            end
            write_reg(REG_TOTAL_FRAMES, 32'(f_pick));
            write_reg(REG_FRAME_PERIOD, p_pick);
            write_reg(REG_PLAY_SPEED,   32'(s_pick));
            write_reg(REG_PLAY_FORWARD, (phase == 0) ? 32'd1 :
                                        (phase == 1) ? 32'd0 : 32'($urandom_range(0, 1)));
            write_reg(REG_LOOP_COUNT,   32'(l_pick));

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == 0 || (!playing && $urandom_range(0, 1) == 0) ||
                    $urandom_range(0, 11) == 0)
                    cmd = CMD_RESTART;
                else
                    cmd = CMD_TICK;
                // aim the spent time at a few frames or a few passes
                span = 64'hFFFF_FFFF;
                if (cfg_speed != 16'd0)
                begin
                    t_eff = (cfg_frames == 16'd0) ? 64'd1 : 64'(cfg_frames);
                    span  = (cfg_period == 32'd0) ? 64'd1 : 64'(cfg_period);
                    span  = span * 256 * ($urandom_range(0, 1) ? 64'd4 : 2 * t_eff + 2);
                    span  = span / cfg_speed;
                    if (span > 64'hFFFF_FFFF)
                        span = 64'hFFFF_FFFF;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: dt = $urandom_range(0, 32'(span));
                    5, 6:          dt = $urandom;
                    7:             dt = $urandom_range(0, 255);
                    8:             dt = 32'd0;
                    default:       dt = 32'hFFFF_FFFF;
                endcase
                offer_request(cmd, dt, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (FLUSH_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
